// ===== rtl/lpd_pkg.sv =====
package lpd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AngleW = 17;
  localparam int unsigned DistW  = 16;
  localparam int unsigned StepW  = 15;

  // raw angle units in one full turn
  localparam logic [15:0] ANGLE_PER_TURN = 16'hB400;

  localparam int unsigned BytesPerSample = 3;
  localparam logic [1:0]  SAMPLE_LAST_BYTE = 2'(BytesPerSample - 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FIRST_SYNC  = 1'b0,
    CFG_SECOND_SYNC = 1'b1
  } cfg_idx_e;

  localparam logic [ByteW-1:0] FIRST_SYNC_RST  = 8'hAA;
  localparam logic [ByteW-1:0] SECOND_SYNC_RST = 8'h55;

  // header byte positions
  localparam logic [2:0] HDR_TYPE     = 3'd0;
  localparam logic [2:0] HDR_COUNT    = 3'd1;
  localparam logic [2:0] HDR_START_LO = 3'd2;
  localparam logic [2:0] HDR_START_HI = 3'd3;
  localparam logic [2:0] HDR_STOP_LO  = 3'd4;
  localparam logic [2:0] HDR_STOP_HI  = 3'd5;
  localparam logic [2:0] HDR_LAST     = 3'd7;

  typedef struct packed {
    logic       hdr_load;
    logic [2:0] hdr_idx;
    logic       pkt_start;    // header done: reset sample count and angle
    logic       div_start;    // launch step divide
    logic       hold_int;
    logic       hold_dlo;
    logic       sample_done;  // third sample byte taken
    logic       emit_marker;
  } cmd_t;

  typedef struct packed {
    logic sync1_match;
    logic sync2_match;
    logic count_zero;
    logic last_sample;
    logic marker;
    logic div_busy;
    logic out_blocked;
  } sts_t;

endpackage

// ===== rtl/lpd_byte_if.sv =====
interface lpd_byte_if;
  import lpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/lpd_rec_if.sv =====
interface lpd_rec_if;
  import lpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              record_kind;
  logic [AngleW-1:0] sample_angle;
  logic [DistW-1:0]  sample_distance;
  logic [ByteW-1:0]  sample_intensity;
  logic              starts_new_scan;

  modport source (
    output valid, output record_kind, output sample_angle, output sample_distance,
    output sample_intensity, output starts_new_scan, input ready
  );
  modport sink (
    input valid, input record_kind, input sample_angle, input sample_distance,
    input sample_intensity, input starts_new_scan, output ready
  );
endinterface

// ===== rtl/lpd_div.sv =====
module lpd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lpd_pkg::StepW-1:0] dividend_i,
  input  logic [lpd_pkg::ByteW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [lpd_pkg::StepW-1:0] quot_o
);
  import lpd_pkg::*;

  localparam int unsigned CntW = $clog2(StepW);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [StepW-1:0] q_q, q_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [ByteW-1:0] div_q, div_d;
  logic [ByteW:0]   trial;
  logic             fits;

  // restoring divide, one quotient bit per cycle, MSB first
  always_comb begin
    trial  = {rem_q, q_q[StepW-1]};
    fits   = trial >= {1'b0, div_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(StepW - 1);
      q_d    = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? ByteW'(trial - {1'b0, div_q}) : trial[ByteW-1:0];
      q_d   = {q_q[StepW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;
endmodule

// ===== rtl/lpd_ctrl.sv =====
module lpd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lpd_pkg::sts_t sts_i,
  output lpd_pkg::cmd_t cmd_o
);
  import lpd_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SECOND,
    ST_HEADER,
    ST_DIVIDE,
    ST_DATA
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] hdr_idx_q, hdr_idx_d;
  logic [1:0] bis_q, bis_d;
  logic       may_emit;
  logic       take;

  always_comb begin
    may_emit = (state_q == ST_HEADER && hdr_idx_q == HDR_LAST) ||
               (state_q == ST_DATA && bis_q == SAMPLE_LAST_BYTE);
    in_ready_o = (state_q != ST_DIVIDE) && !(may_emit && sts_i.out_blocked);
    take = in_valid_i && in_ready_o;

    cmd_o         = '0;
    cmd_o.hdr_idx = hdr_idx_q;
    state_d       = state_q;
    hdr_idx_d     = hdr_idx_q;
    bis_d         = bis_q;

    case (state_q)
      ST_HUNT: begin
        if (take && sts_i.sync1_match) begin
          state_d = ST_SECOND;
        end
      end
      ST_SECOND: begin
        if (take) begin
          hdr_idx_d = '0;
          state_d   = sts_i.sync2_match ? ST_HEADER : ST_HUNT;
        end
      end
      ST_HEADER: begin
        if (take) begin
          cmd_o.hdr_load = 1'b1;
          if (hdr_idx_q != HDR_LAST) begin
            hdr_idx_d = hdr_idx_q + 3'd1;
          end else begin
            hdr_idx_d       = '0;
            bis_d           = '0;
            cmd_o.pkt_start = 1'b1;
            if (sts_i.count_zero) begin
              state_d           = ST_HUNT;
              cmd_o.emit_marker = sts_i.marker;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIVIDE;
            end
          end
        end
      end
      ST_DIVIDE: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (take) begin
          case (bis_q)
            2'd0: begin
              cmd_o.hold_int = 1'b1;
              bis_d          = 2'd1;
            end
            2'd1: begin
              cmd_o.hold_dlo = 1'b1;
              bis_d          = SAMPLE_LAST_BYTE;
            end
            default: begin
              cmd_o.sample_done = 1'b1;
              bis_d             = '0;
              if (sts_i.last_sample) begin
                state_d           = ST_HUNT;
                cmd_o.emit_marker = sts_i.marker;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HUNT;
      hdr_idx_q <= '0;
      bis_q     <= '0;
    end else begin
      state_q   <= state_d;
      hdr_idx_q <= hdr_idx_d;
      bis_q     <= bis_d;
    end
  end
endmodule

// ===== rtl/lpd_datapath.sv =====
module lpd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [lpd_pkg::ByteW-1:0]  cfg_data_i,
  input  logic [lpd_pkg::ByteW-1:0]  rx_byte_i,
  input  lpd_pkg::cmd_t              cmd_i,
  output lpd_pkg::sts_t              sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       record_kind_o,
  output logic [lpd_pkg::AngleW-1:0] sample_angle_o,
  output logic [lpd_pkg::DistW-1:0]  sample_distance_o,
  output logic [lpd_pkg::ByteW-1:0]  sample_intensity_o,
  output logic                       starts_new_scan_o
);
  import lpd_pkg::*;

  logic [ByteW-1:0]  sync1_q, sync2_q;
  logic              marker_q;
  logic [ByteW-1:0]  count_q;
  logic [15:0]       start_q, stop_q;
  logic [ByteW-1:0]  int_q, dlo_q;
  logic [ByteW-1:0]  sample_n_q;
  logic [AngleW-1:0] acc_q, prev_q;
  logic              step_ok_q;
  logic              out_valid_q, out_valid_d;
  logic              kind_q;
  logic [AngleW-1:0] angle_q;
  logic [DistW-1:0]  dist_q;
  logic [ByteW-1:0]  inten_q;
  logic              fresh_q;

  logic [15:0]       span;
  logic              step_ok;
  logic [StepW-1:0]  quot;
  logic [StepW-1:0]  step;
  logic [ByteW-1:0]  sample_n_nxt;
  logic              emit_sample;
  logic              div_busy;

  always_comb begin
    // span wraps through the end of the turn when stop is below start
    span = (stop_q < start_q) ? (ANGLE_PER_TURN - start_q + stop_q) : (stop_q - start_q);
    step_ok      = !span[15] && (span > 16'd1) && (count_q >= 8'd2);
    step         = step_ok_q ? quot : '0;
    sample_n_nxt = sample_n_q + 8'd1;
    emit_sample  = cmd_i.sample_done && !marker_q;
    out_valid_d  = (out_valid_q && !out_ready_i) || emit_sample || cmd_i.emit_marker;

    sts_o.sync1_match = rx_byte_i == sync1_q;
    sts_o.sync2_match = rx_byte_i == sync2_q;
    sts_o.count_zero  = count_q == '0;
    sts_o.last_sample = sample_n_nxt >= count_q;
    sts_o.marker      = marker_q;
    sts_o.div_busy    = div_busy;
    sts_o.out_blocked = out_valid_q && !out_ready_i;
  end

  lpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (span[StepW-1:0]),
    .divisor_i  (count_q - 8'd1),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync1_q     <= FIRST_SYNC_RST;
      sync2_q     <= SECOND_SYNC_RST;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_SYNC:  sync1_q <= cfg_data_i;
          CFG_SECOND_SYNC: sync2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit_sample) begin
        prev_q <= acc_q;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_load) begin
      case (cmd_i.hdr_idx)
        HDR_TYPE:     marker_q      <= rx_byte_i[0];
        HDR_COUNT:    count_q       <= rx_byte_i;
        HDR_START_LO: start_q[7:0]  <= rx_byte_i;
        HDR_START_HI: start_q[15:8] <= rx_byte_i;
        HDR_STOP_LO:  stop_q[7:0]   <= rx_byte_i;
        HDR_STOP_HI:  stop_q[15:8]  <= rx_byte_i;
        default: ;
      endcase
    end
    if (cmd_i.div_start) begin
      step_ok_q <= step_ok;
    end
    if (cmd_i.pkt_start) begin
      acc_q      <= {1'b0, start_q};
      sample_n_q <= '0;
    end else if (cmd_i.sample_done) begin
      // running sum stands in for start + step * sample number
      acc_q      <= acc_q + AngleW'(step);
      sample_n_q <= sample_n_nxt;
    end
    if (cmd_i.hold_int) begin
      int_q <= rx_byte_i;
    end
    if (cmd_i.hold_dlo) begin
      dlo_q <= rx_byte_i;
    end
    if (emit_sample) begin
      kind_q  <= 1'b0;
      angle_q <= acc_q;
      dist_q  <= {rx_byte_i, dlo_q};
      inten_q <= int_q;
      fresh_q <= acc_q < prev_q;
    end else if (cmd_i.emit_marker) begin
      kind_q  <= 1'b1;
      angle_q <= '0;
      dist_q  <= '0;
      inten_q <= '0;
      fresh_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign record_kind_o      = kind_q;
  assign sample_angle_o     = angle_q;
  assign sample_distance_o  = dist_q;
  assign sample_intensity_o = inten_q;
  assign starts_new_scan_o  = fresh_q;
endmodule

// ===== rtl/lidar_packet_deframer.sv =====
// Channel  | Modport | Payload                                      | Transaction
// rx_i     | sink    | rx_byte[7:0]                                 | one serial byte
// rec_o    | source  | record_kind, sample_angle[16:0],             | one sample or
//          |         | sample_distance[15:0], sample_intensity[7:0],| rotation marker
//          |         | starts_new_scan                              |
// cfg      | write   | cfg_we_i, cfg_idx_i, cfg_data_i              | sync byte write
//
// One byte per cycle in every parse phase. After the last header byte of a packet
// with samples, rx_i.ready stays low in the divide wait state until the step
// divider has finished.
// Reset (rst_ni low, async) returns to the sync hunt, sets the sync bytes to
// 0xAA / 0x55 and clears the previous sample angle.
// Apart from the divide wait, rx_i is held off only on a byte that may produce
// a record while rec_o still holds an untaken one.
module lidar_packet_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [lpd_pkg::ByteW-1:0] cfg_data_i,
  lpd_byte_if.sink                  rx_i,
  lpd_rec_if.source                 rec_o
);
  import lpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: sync hunt, header count, divide wait, sample byte count
  lpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // header fields, step divider, angle accumulator, result register
  lpd_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .rx_byte_i          (rx_i.rx_byte),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (rec_o.ready),
    .out_valid_o        (rec_o.valid),
    .record_kind_o      (rec_o.record_kind),
    .sample_angle_o     (rec_o.sample_angle),
    .sample_distance_o  (rec_o.sample_distance),
    .sample_intensity_o (rec_o.sample_intensity),
    .starts_new_scan_o  (rec_o.starts_new_scan)
  );
endmodule
